// File: sv/rational_arithmetic_unit_core_assert.svh
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RAU_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RAU_ASSERT(label, clk, rst_n, prop)
`define RAU_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: sv/rau_pkg.sv
package rau_pkg;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_A,
    BK_MUL_B,
    BK_MUL_C,
    BK_COMBINE,
    BK_GCD_PRE,
    BK_GCD_ODD_A,
    BK_GCD_LOOP,
    BK_GCD_POST,
    BK_DIV_N,
    BK_DIV_D,
    BK_CHECK,
    BK_OUT
  } bk_state_t;

endpackage

// File: sv/rau_front.sv
module rau_front #(
  parameter int unsigned W = rau_pkg::OperandWidth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic signed [W-1:0]  in_a_num,
  input  logic signed [W-1:0]  in_a_den,
  input  logic signed [W-1:0]  in_b_num,
  input  logic signed [W-1:0]  in_b_den,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [1:0]           q_cmd,
  output logic [1:0]           q_status,
  output logic [W-1:0]         q_an,
  output logic [W-1:0]         q_ad,
  output logic [W-1:0]         q_bn,
  output logic [W-1:0]         q_bd,
  output logic [3:0]           q_sign
);

  localparam int unsigned D = rau_pkg::QueueDepth;
  localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned EW = 2 + 2 + 4 * W + 4;

  logic [EW-1:0] mem_r [D];
  logic [PW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          push, pop;
  logic [W-1:0]  an, ad, bn, bd;
  logic [1:0]    st;
  logic [EW-1:0] ent;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
  endfunction

  always_comb begin
    an = mag(in_a_num);
    ad = mag(in_a_den);
    bn = mag(in_b_num);
    bd = mag(in_b_den);
    // zero denominators take priority over division by zero
    if (ad == '0 || bd == '0) begin
      st = rau_pkg::ST_ZERO_DEN;
    end else if (in_cmd == rau_pkg::CMD_DIV && bn == '0) begin
      st = rau_pkg::ST_DIV_ZERO;
    end else begin
      st = rau_pkg::ST_OK;
    end
    ent = {in_cmd, st, an, ad, bn, bd,
           in_a_num[W-1], in_a_den[W-1], in_b_num[W-1], in_b_den[W-1]};
  end

  assign in_ready = (cnt_r != (PW+1)'(D));
  assign q_valid  = (cnt_r != '0);
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign {q_cmd, q_status, q_an, q_ad, q_bn, q_bd, q_sign} = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ((wp_r == PW'(D-1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop  ? ((rp_r == PW'(D-1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= ent;
    end
  end

endmodule

// File: sv/rau_back.sv
`include "rational_arithmetic_unit_core_assert.svh"

module rau_back #(
  parameter int unsigned W = rau_pkg::OperandWidth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [1:0]          q_cmd,
  input  logic [1:0]          q_status,
  input  logic [W-1:0]        q_an,
  input  logic [W-1:0]        q_ad,
  input  logic [W-1:0]        q_bn,
  input  logic [W-1:0]        q_bd,
  input  logic [3:0]          q_sign,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_res_num,
  output logic [W-2:0]        out_res_den,
  output logic [1:0]          out_status
);

  localparam int unsigned WW = 2 * W + 1;
  localparam int unsigned KW = $clog2(WW + 1);
  localparam int unsigned CW = $clog2(WW + 1);

  rau_pkg::bk_state_t state_r, state_nxt;

  logic [1:0]    cmd_r;
  logic [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic [3:0]    sg_r;
  logic [2*W-1:0] p_r;
  logic [2*W-1:0] t1_r, t2_r;
  logic [WW-1:0] n_r, d_r, ga_r, gb_r, q_r, rm_r;
  logic          sn_r, sd_r;
  logic [KW-1:0] k_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  ma, mb;
  logic [WW-1:0] rsh, rsub, dvs, numsrc;
  logic          rge;

  logic signed [W-1:0] rn_r;
  logic [W-2:0]       rd_r;
  logic [1:0]         rs_r;

  logic s_a, s_ad, s_b, s_bd;
  assign {s_a, s_ad, s_b, s_bd} = sg_r;

  // one shared multiplier, operands picked by phase
  always_comb begin
    ma = an_r;
    mb = bd_r;
    unique case (state_r)
      rau_pkg::BK_MUL_A: begin
        ma = an_r;
        mb = (cmd_r == rau_pkg::CMD_MUL) ? bn_r : bd_r;
      end
      rau_pkg::BK_MUL_B: begin
        ma = (cmd_r == rau_pkg::CMD_DIV) ? ad_r : bn_r;
        mb = (cmd_r == rau_pkg::CMD_DIV) ? bn_r : ad_r;
      end
      rau_pkg::BK_MUL_C: begin
        ma = ad_r;
        mb = bd_r;
      end
      default: begin
        ma = an_r;
        mb = bd_r;
      end
    endcase
  end

  assign dvs    = ga_r;
  assign numsrc = (state_r == rau_pkg::BK_DIV_N) ? n_r : d_r;
  assign rsh    = {rm_r[WW-2:0], numsrc[WW-1 - cnt_r[CW-1:0]]};
  assign rge    = rsh >= dvs;
  assign rsub   = rsh - dvs;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rau_pkg::BK_IDLE:
        if (q_valid) begin
          state_nxt = (q_status != rau_pkg::ST_OK) ? rau_pkg::BK_OUT : rau_pkg::BK_MUL_A;
        end
      rau_pkg::BK_MUL_A: state_nxt = rau_pkg::BK_MUL_B;
      rau_pkg::BK_MUL_B: state_nxt = rau_pkg::BK_MUL_C;
      rau_pkg::BK_MUL_C: state_nxt = rau_pkg::BK_COMBINE;
      rau_pkg::BK_COMBINE: state_nxt = rau_pkg::BK_GCD_PRE;
      rau_pkg::BK_GCD_PRE:
        if (ga_r == '0 || gb_r == '0) begin
          state_nxt = rau_pkg::BK_DIV_N;
        end else if (ga_r[0] || gb_r[0]) begin
          state_nxt = rau_pkg::BK_GCD_ODD_A;
        end
      rau_pkg::BK_GCD_ODD_A:
        if (ga_r[0]) state_nxt = rau_pkg::BK_GCD_LOOP;
      rau_pkg::BK_GCD_LOOP:
        if (gb_r == '0) state_nxt = rau_pkg::BK_GCD_POST;
      rau_pkg::BK_GCD_POST:
        if (k_r == '0) state_nxt = rau_pkg::BK_DIV_N;
      rau_pkg::BK_DIV_N:
        if (cnt_r == CW'(WW - 1)) state_nxt = rau_pkg::BK_DIV_D;
      rau_pkg::BK_DIV_D:
        if (cnt_r == CW'(WW - 1)) state_nxt = rau_pkg::BK_CHECK;
      rau_pkg::BK_CHECK: state_nxt = rau_pkg::BK_OUT;
      rau_pkg::BK_OUT:
        if (!out_valid || out_ready) state_nxt = rau_pkg::BK_IDLE;
      default: state_nxt = rau_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state_r == rau_pkg::BK_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rau_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rau_pkg::BK_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      rau_pkg::BK_IDLE: begin
        cmd_r <= q_cmd;
        an_r  <= q_an;
        ad_r  <= q_ad;
        bn_r  <= q_bn;
        bd_r  <= q_bd;
        sg_r  <= q_sign;
        rs_r  <= q_status;
        rn_r  <= '0;
        rd_r  <= '0;
      end
      rau_pkg::BK_MUL_A: begin
        p_r  <= ma * mb;
      end
      rau_pkg::BK_MUL_B: begin
        t1_r <= p_r;
        p_r  <= ma * mb;
      end
      rau_pkg::BK_MUL_C: begin
        t2_r <= p_r;
        p_r  <= ma * mb;
      end
      rau_pkg::BK_COMBINE: begin
        logic s1, s2;
        logic [WW-1:0] nv, dv;
        s1 = s_a ^ s_bd;
        s2 = s_b ^ s_ad ^ (cmd_r == rau_pkg::CMD_SUB);
        if (cmd_r == rau_pkg::CMD_ADD || cmd_r == rau_pkg::CMD_SUB) begin
          dv   = {1'b0, p_r};
          sd_r <= s_ad ^ s_bd;
          if (s1 == s2) begin
            nv = {1'b0, t1_r} + {1'b0, t2_r};
            sn_r <= s1;
          end else if (t1_r >= t2_r) begin
            nv = {1'b0, t1_r - t2_r};
            sn_r <= s1;
          end else begin
            nv = {1'b0, t2_r - t1_r};
            sn_r <= s2;
          end
        end else if (cmd_r == rau_pkg::CMD_MUL) begin
          nv   = {1'b0, t1_r};
          dv   = {1'b0, p_r};
          sn_r <= s_a ^ s_b;
          sd_r <= s_ad ^ s_bd;
        end else begin
          nv   = {1'b0, t1_r};
          dv   = {1'b0, t2_r};
          sn_r <= s_a ^ s_bd;
          sd_r <= s_ad ^ s_b;
        end
        n_r  <= nv;
        d_r  <= dv;
        ga_r <= nv;
        gb_r <= dv;
        k_r  <= '0;
      end
      rau_pkg::BK_GCD_PRE: begin
        if (ga_r == '0 || gb_r == '0) begin
          ga_r  <= (ga_r == '0) ? gb_r : ga_r;
          cnt_r <= '0;
          rm_r  <= '0;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          k_r  <= k_r + 1'b1;
        end
      end
      rau_pkg::BK_GCD_ODD_A: begin
        if (!ga_r[0]) ga_r <= ga_r >> 1;
      end
      rau_pkg::BK_GCD_LOOP: begin
        if (gb_r != '0) begin
          if (!gb_r[0]) begin
            gb_r <= gb_r >> 1;
          end else if (ga_r > gb_r) begin
            ga_r <= gb_r;
            gb_r <= ga_r - gb_r;
          end else begin
            gb_r <= gb_r - ga_r;
          end
        end
      end
      rau_pkg::BK_GCD_POST: begin
        if (k_r != '0) begin
          ga_r <= ga_r << 1;
          k_r  <= k_r - 1'b1;
        end else begin
          cnt_r <= '0;
          rm_r  <= '0;
        end
      end
      rau_pkg::BK_DIV_N, rau_pkg::BK_DIV_D: begin
        rm_r <= rge ? rsub : rsh;
        q_r  <= {q_r[WW-2:0], rge};
        if (cnt_r == CW'(WW - 1)) begin
          cnt_r <= '0;
          rm_r  <= '0;
          if (state_r == rau_pkg::BK_DIV_N) n_r <= {q_r[WW-2:0], rge};
          else d_r <= {q_r[WW-2:0], rge};
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      rau_pkg::BK_CHECK: begin
        logic neg;
        logic [WW-1:0] lim;
        neg = (sn_r ^ sd_r) && (n_r != '0);
        lim = neg ? (WW'(1) << (W-1)) : ((WW'(1) << (W-1)) - 1'b1);
        if (d_r > ((WW'(1) << (W-1)) - 1'b1) || n_r > lim) begin
          rs_r <= rau_pkg::ST_OVERFLOW;
        end else begin
          rn_r <= neg ? (~n_r[W-1:0] + 1'b1) : n_r[W-1:0];
          rd_r <= d_r[W-2:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == rau_pkg::BK_OUT && (!out_valid || out_ready)) begin
      out_res_num <= rn_r;
      out_res_den <= rd_r;
      out_status  <= rs_r;
    end
  end

  `RAU_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `RAU_ASSERT(a_err_zero, clk, rst_n,
    out_valid && out_status != rau_pkg::ST_OK |-> out_res_num == '0 && out_res_den == '0)
  `RAU_ASSERT(a_ok_den, clk, rst_n,
    out_valid && out_status == rau_pkg::ST_OK |-> out_res_den != '0)
  `RAU_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

// File: sv/rational_arithmetic_unit_core.sv
// error items go straight to the output stage; other items pass through a binary gcd
// and two bit-serial divisions
// throughput: one item at a time in the back end; a two-entry queue lets the front accept ahead
// reset: synchronous active-low rst_n clears queue pointers, the sequencer and out_valid
module rational_arithmetic_unit_core #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidth
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_cmd,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [OPERAND_WIDTH-1:0] out_res_num,
  output logic [OPERAND_WIDTH-2:0]        out_res_den,
  output logic [1:0]                      out_status
);

  logic                     q_valid, q_ready;
  logic [1:0]               q_cmd, q_status;
  logic [OPERAND_WIDTH-1:0] q_an, q_ad, q_bn, q_bd;
  logic [3:0]               q_sign;

  rau_front #(.W(OPERAND_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .q_valid, .q_ready, .q_cmd, .q_status,
    .q_an, .q_ad, .q_bn, .q_bd, .q_sign
  );

  rau_back #(.W(OPERAND_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .q_status,
    .q_an, .q_ad, .q_bn, .q_bd, .q_sign,
    .out_valid, .out_ready, .out_res_num, .out_res_den, .out_status
  );

endmodule
